### rtl/core/pointer_click_drag_classifier_defines.svh
// Assertion macros shared by the pointer click/drag classifier checkers.
`ifndef POINTER_CLICK_DRAG_CLASSIFIER_DEFINES_SVH
`define POINTER_CLICK_DRAG_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PCDC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PCDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pcdc_pkg.sv
// Types and constants of the pointer click/drag classifier.
package pcdc_pkg;

    localparam int IN_W  = 56;
    localparam int OUT_W = 40;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 32;

    localparam logic [CFG_AW-1:0] REG_CLICK_TIME_LIMIT = 2'd0;
    localparam logic [CFG_AW-1:0] REG_DRAG_DISTANCE_SQ = 2'd1;

    localparam logic [23:0] CLICK_TIME_LIMIT_RST = 24'd300000;
    localparam logic [31:0] DRAG_DISTANCE_SQ_RST = 32'd4;
    localparam logic [23:0] ELAPSED_MAX          = 24'hFFFFFF;

    localparam logic [2:0] MODE_WAIT      = 3'd0;
    localparam logic [2:0] MODE_DETECT    = 3'd1;
    localparam logic [2:0] MODE_SEL_START = 3'd2;
    localparam logic [2:0] MODE_SELECTED  = 3'd3;
    localparam logic [2:0] MODE_DRAGGING  = 3'd4;
    localparam logic [2:0] MODE_STOPPED   = 3'd5;

    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_DRAG_START = 3'd1;
    localparam logic [2:0] EV_DRAG_CONT  = 3'd2;
    localparam logic [2:0] EV_DRAG_STOP  = 3'd3;
    localparam logic [2:0] EV_CLICK      = 3'd4;
    localparam logic [2:0] EV_CLICK_END  = 3'd5;

    typedef struct packed {
        logic               button_down;
        logic signed [15:0] pointer_x;
        logic signed [15:0] pointer_y;
        logic               hit_inside;
        logic [15:0]        tick_time;
        logic               listener_accepts;
    } item_t;

    typedef struct packed {
        logic [2:0]         event_code;
        logic signed [15:0] event_x;
        logic signed [15:0] event_y;
        logic [2:0]         mode_now;
    } result_t;

    typedef struct packed {
        logic [23:0] click_time_limit;
        logic [31:0] drag_distance_sq;
    } cfg_t;

endpackage

### rtl/core/pcdc_cfg_regs.sv
// Configuration registers of the pointer click/drag classifier.
module pcdc_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [pcdc_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [pcdc_pkg::CFG_DW-1:0]  cfg_wdata,
    output pcdc_pkg::cfg_t               cfg
);

    logic [23:0] click_time_limit_reg;
    logic [31:0] drag_distance_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_time_limit_reg <= pcdc_pkg::CLICK_TIME_LIMIT_RST;
            drag_distance_sq_reg <= pcdc_pkg::DRAG_DISTANCE_SQ_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pcdc_pkg::REG_CLICK_TIME_LIMIT:
                begin
                    click_time_limit_reg <= cfg_wdata[23:0];
                end
                pcdc_pkg::REG_DRAG_DISTANCE_SQ:
                begin
                    drag_distance_sq_reg <= cfg_wdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.click_time_limit = click_time_limit_reg;
    assign cfg.drag_distance_sq = drag_distance_sq_reg;

endmodule

### rtl/core/pcdc_in_stage.sv
// Input register: captures one item and holds it until the classifier takes it.
module pcdc_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pcdc_pkg::IN_W-1:0]   s_tdata,
    input  logic                        take,
    output logic                        item_valid,
    output pcdc_pkg::item_t             item
);

    logic            valid_reg;
    logic            valid_next;
    pcdc_pkg::item_t item_reg;
    pcdc_pkg::item_t item_next;
    logic            load;

    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        item_next.button_down      = s_tdata[0];
        item_next.pointer_x        = s_tdata[16:1];
        item_next.pointer_y        = s_tdata[32:17];
        item_next.hit_inside       = s_tdata[33];
        item_next.tick_time        = s_tdata[49:34];
        item_next.listener_accepts = s_tdata[50];
    end

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/core/pcdc_classify.sv
// Click/drag state machine: press position, elapsed time and per-item event.
module pcdc_classify (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  pcdc_pkg::item_t   item,
    input  pcdc_pkg::cfg_t    cfg,
    output pcdc_pkg::result_t result
);

    logic [2:0]         mode_reg;
    logic [2:0]         mode_next;
    logic [23:0]        elapsed_reg;
    logic [23:0]        elapsed_next;
    logic signed [15:0] press_x_reg;
    logic signed [15:0] press_x_next;
    logic signed [15:0] press_y_reg;
    logic signed [15:0] press_y_next;

    logic [2:0]         ev;
    logic [24:0]        elapsed_sum;
    logic [23:0]        elapsed_sat;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] sq_x;
    logic signed [33:0] sq_y;
    logic [33:0]        dist_sq;
    logic               far;

    assign elapsed_sum = {1'b0, elapsed_reg} + {9'd0, item.tick_time};
    assign elapsed_sat = elapsed_sum[24] ? pcdc_pkg::ELAPSED_MAX : elapsed_sum[23:0];

    assign dx      = {item.pointer_x[15], item.pointer_x} - {press_x_reg[15], press_x_reg};
    assign dy      = {item.pointer_y[15], item.pointer_y} - {press_y_reg[15], press_y_reg};
    assign sq_x    = dx * dx;
    assign sq_y    = dy * dy;
    assign dist_sq = {1'b0, sq_x[32:0]} + {1'b0, sq_y[32:0]};
    assign far     = dist_sq > {2'b00, cfg.drag_distance_sq};

    always_comb
    begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        press_x_next = press_x_reg;
        press_y_next = press_y_reg;
        ev           = pcdc_pkg::EV_NONE;
        case (mode_reg)
            pcdc_pkg::MODE_WAIT:
            begin
                if (item.button_down && item.hit_inside)
                begin
                    elapsed_next = '0;
                    press_x_next = item.pointer_x;
                    press_y_next = item.pointer_y;
                    mode_next    = pcdc_pkg::MODE_DETECT;
                end
            end
            pcdc_pkg::MODE_DETECT:
            begin
                elapsed_next = elapsed_sat;
                if (item.button_down)
                begin
                    if (far)
                    begin
                        ev        = pcdc_pkg::EV_DRAG_START;
                        mode_next = item.listener_accepts ? pcdc_pkg::MODE_DRAGGING
                                                          : pcdc_pkg::MODE_DETECT;
                    end
                end
                else if (elapsed_sat < cfg.click_time_limit)
                begin
                    ev        = pcdc_pkg::EV_CLICK;
                    mode_next = item.listener_accepts ? pcdc_pkg::MODE_SEL_START
                                                      : pcdc_pkg::MODE_DETECT;
                end
                else
                begin
                    mode_next = pcdc_pkg::MODE_WAIT;
                end
            end
            pcdc_pkg::MODE_SEL_START:
            begin
                mode_next = pcdc_pkg::MODE_SELECTED;
            end
            pcdc_pkg::MODE_SELECTED:
            begin
                if (item.button_down)
                begin
                    ev        = pcdc_pkg::EV_CLICK_END;
                    mode_next = pcdc_pkg::MODE_STOPPED;
                end
            end
            pcdc_pkg::MODE_DRAGGING:
            begin
                if (!item.button_down)
                begin
                    ev        = pcdc_pkg::EV_DRAG_STOP;
                    mode_next = pcdc_pkg::MODE_STOPPED;
                end
                else
                begin
                    ev = pcdc_pkg::EV_DRAG_CONT;
                end
            end
            pcdc_pkg::MODE_STOPPED:
            begin
                if (!item.button_down)
                    mode_next = pcdc_pkg::MODE_WAIT;
            end
            default:
            begin
                mode_next = pcdc_pkg::MODE_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= pcdc_pkg::MODE_WAIT;
            elapsed_reg <= '0;
            press_x_reg <= '0;
            press_y_reg <= '0;
        end
        else if (take)
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            press_x_reg <= press_x_next;
            press_y_reg <= press_y_next;
        end
    end

    assign result.event_code = ev;
    assign result.event_x    = (ev != pcdc_pkg::EV_NONE) ? item.pointer_x : '0;
    assign result.event_y    = (ev != pcdc_pkg::EV_NONE) ? item.pointer_y : '0;
    assign result.mode_now   = mode_next;

endmodule

### rtl/core/pcdc_out_stage.sv
// Result register: holds one result item until the downstream side takes it.
module pcdc_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  pcdc_pkg::result_t           result,
    output logic                        take,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pcdc_pkg::OUT_W-1:0]  m_tdata
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [pcdc_pkg::OUT_W-1:0] data_reg;
    logic [pcdc_pkg::OUT_W-1:0] data_next;
    logic                       room;

    assign room = !valid_reg || m_tready;
    assign take = item_valid && room;

    assign data_next = {2'b00, result.mode_now, result.event_y,
                        result.event_x, result.event_code};

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

### rtl/core/pointer_click_drag_classifier.sv
// Pointer click/drag classifier: one pointer tick in, one event item out. Every
// accepted tick yields exactly one result item, which passes the input register and
// then the result register before it shows on the master side, and a new tick is
// taken every cycle as long as the result register can drain; the
// single per-tick update of the six-state press machine sets that rate. With the
// master side stalled the block holds two ticks and then drops s_tready.
// Write configuration only while no tick is in flight; the block does not check it.
module pointer_click_drag_classifier (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [0] button_down, [16:1] pointer_x, [32:17] pointer_y, [33] hit_inside,
    // [49:34] tick_time, [50] listener_accepts, [55:51] zero
    input  logic [pcdc_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [2:0] event_code, [18:3] event_x, [34:19] event_y, [37:35] mode_now,
    // [39:38] zero
    output logic [pcdc_pkg::OUT_W-1:0]  m_tdata,
    input  logic                        cfg_we,
    input  logic [pcdc_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [pcdc_pkg::CFG_DW-1:0] cfg_wdata
);

    pcdc_pkg::cfg_t    cfg;
    pcdc_pkg::item_t   item;
    pcdc_pkg::result_t result;
    logic              item_valid;
    logic              take;

    pcdc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pcdc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    pcdc_classify u_classify (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    pcdc_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### rtl/core/pcdc_checker.sv
// Port-level checks of the pointer click/drag classifier, bound to the top level.
`include "pointer_click_drag_classifier_defines.svh"

module pcdc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [pcdc_pkg::OUT_W-1:0]  m_tdata
);

    logic [2:0]  ev;
    logic [31:0] pos;
    logic [2:0]  mode;

    assign ev   = m_tdata[2:0];
    assign pos  = m_tdata[34:3];
    assign mode = m_tdata[37:35];

    `PCDC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result item changed while stalled")
    `PCDC_ASSERT_IMPL(a_none_zero_pos, m_tvalid && ev == pcdc_pkg::EV_NONE, pos == '0,
        "no event but position not zero")
    `PCDC_ASSERT_IMPL(a_stop_mode, m_tvalid && (ev == pcdc_pkg::EV_DRAG_STOP ||
        ev == pcdc_pkg::EV_CLICK_END), mode == pcdc_pkg::MODE_STOPPED,
        "stop event without stopped mode")
    `PCDC_ASSERT_IMPL(a_cont_mode, m_tvalid && ev == pcdc_pkg::EV_DRAG_CONT,
        mode == pcdc_pkg::MODE_DRAGGING, "drag continue outside dragging")
    `PCDC_ASSERT_IMPL(a_click_mode, m_tvalid && ev == pcdc_pkg::EV_CLICK,
        mode == pcdc_pkg::MODE_SEL_START || mode == pcdc_pkg::MODE_DETECT,
        "click with wrong mode")

endmodule

bind pointer_click_drag_classifier pcdc_checker u_pcdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/click_drag_checker.sv
// Checker for the pointer click/drag classifier: predicts every event item and compares.
`timescale 1ns / 1ps
module click_drag_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [pcdc_pkg::IN_W-1:0]   s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [pcdc_pkg::OUT_W-1:0]  m_tdata,
    input  logic                        cfg_we,
    input  logic [pcdc_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [pcdc_pkg::CFG_DW-1:0] cfg_wdata,
    output int                          errors,
    output int                          pending
);

    pcdc_pkg::result_t  expected_events[$];
    logic [2:0]         gesture_mode;
    logic [23:0]        press_time;
    logic signed [15:0] press_x;
    logic signed [15:0] press_y;
    logic [23:0]        click_limit;
    logic [31:0]        drag_sq;
    int                 mismatch_total;

    function automatic pcdc_pkg::result_t classify_tick(input pcdc_pkg::item_t tick);
        pcdc_pkg::result_t res;
        logic [24:0]       sum;
        longint            dx;
        longint            dy;
        res.event_code = pcdc_pkg::EV_NONE;
        case (gesture_mode)
            pcdc_pkg::MODE_WAIT:
                if (tick.button_down && tick.hit_inside)
                begin
                    press_time   = '0;
                    press_x      = tick.pointer_x;
                    press_y      = tick.pointer_y;
                    gesture_mode = pcdc_pkg::MODE_DETECT;
                end
            pcdc_pkg::MODE_DETECT:
            begin
                sum        = {1'b0, press_time} + {9'b0, tick.tick_time};
                press_time = sum[24] ? pcdc_pkg::ELAPSED_MAX : sum[23:0];
                if (tick.button_down)
                begin
                    dx = longint'($signed(tick.pointer_x)) - longint'(press_x);
                    dy = longint'($signed(tick.pointer_y)) - longint'(press_y);
                    if (dx * dx + dy * dy > longint'({32'b0, drag_sq}))
                    begin
                        res.event_code = pcdc_pkg::EV_DRAG_START;
                        gesture_mode   = tick.listener_accepts ? pcdc_pkg::MODE_DRAGGING
                                                               : pcdc_pkg::MODE_DETECT;
                    end
                end
                else if (press_time < click_limit)
                begin
                    res.event_code = pcdc_pkg::EV_CLICK;
                    gesture_mode   = tick.listener_accepts ? pcdc_pkg::MODE_SEL_START
                                                           : pcdc_pkg::MODE_DETECT;
                end
                else
                    gesture_mode = pcdc_pkg::MODE_WAIT;
            end
            pcdc_pkg::MODE_SEL_START:
                gesture_mode = pcdc_pkg::MODE_SELECTED;
            pcdc_pkg::MODE_SELECTED:
                if (tick.button_down)
                begin
                    res.event_code = pcdc_pkg::EV_CLICK_END;
                    gesture_mode   = pcdc_pkg::MODE_STOPPED;
                end
            pcdc_pkg::MODE_DRAGGING:
                if (!tick.button_down)
                begin
                    res.event_code = pcdc_pkg::EV_DRAG_STOP;
                    gesture_mode   = pcdc_pkg::MODE_STOPPED;
                end
                else
                    res.event_code = pcdc_pkg::EV_DRAG_CONT;
            pcdc_pkg::MODE_STOPPED:
                if (!tick.button_down)
                    gesture_mode = pcdc_pkg::MODE_WAIT;
            default:
                gesture_mode = pcdc_pkg::MODE_WAIT;
        endcase
        res.event_x  = (res.event_code != pcdc_pkg::EV_NONE) ? tick.pointer_x : '0;
        res.event_y  = (res.event_code != pcdc_pkg::EV_NONE) ? tick.pointer_y : '0;
        res.mode_now = gesture_mode;
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pcdc_pkg::item_t   tick;
        pcdc_pkg::result_t want;
        pcdc_pkg::result_t got;
        if (!rst_n)
        begin
            expected_events.delete();
            gesture_mode   = pcdc_pkg::MODE_WAIT;
            press_time     = '0;
            press_x        = '0;
            press_y        = '0;
            click_limit    = pcdc_pkg::CLICK_TIME_LIMIT_RST;
            drag_sq        = pcdc_pkg::DRAG_DISTANCE_SQ_RST;
            mismatch_total = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    pcdc_pkg::REG_CLICK_TIME_LIMIT: click_limit = cfg_wdata[23:0];
                    pcdc_pkg::REG_DRAG_DISTANCE_SQ: drag_sq = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                tick.button_down      = s_tdata[0];
                tick.pointer_x        = s_tdata[16:1];
                tick.pointer_y        = s_tdata[32:17];
                tick.hit_inside       = s_tdata[33];
                tick.tick_time        = s_tdata[49:34];
                tick.listener_accepts = s_tdata[50];
                expected_events.push_back(classify_tick(tick));
            end
            if (m_tvalid && m_tready)
            begin
                got.event_code = m_tdata[2:0];
                got.event_x    = m_tdata[18:3];
                got.event_y    = m_tdata[34:19];
                got.mode_now   = m_tdata[37:35];
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected item: expected none, actual %h", $time, m_tdata);
                    mismatch_total++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_code", int'(want.event_code), int'(got.event_code));
                    check_field("event_x", int'(want.event_x), int'(got.event_x));
                    check_field("event_y", int'(want.event_y), int'(got.event_y));
                    check_field("mode_now", int'(want.mode_now), int'(got.mode_now));
                end
            end
            errors  <= mismatch_total;
            pending <= expected_events.size();
        end
    end

endmodule

### test/tb_pointer_click_drag_classifier.sv
// Testbench top for the pointer click/drag classifier: gesture stimulus, pacing and verdict.
`timescale 1ns / 1ps
module tb_pointer_click_drag_classifier;

    localparam logic [pcdc_pkg::CFG_AW-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [pcdc_pkg::CFG_AW-1:0] REG_SPARE_3 = 2'd3;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 250;

    typedef enum int {G_CLICK, G_DRAG, G_LONG_PRESS, G_REFUSED, G_NOISE, G_NONE} gesture_t;
    typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PERIODIC} ready_style_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [pcdc_pkg::IN_W-1:0]   s_tdata = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [pcdc_pkg::OUT_W-1:0]  m_tdata;
    logic                        cfg_we = 1'b0;
    logic [pcdc_pkg::CFG_AW-1:0] cfg_addr = '0;
    logic [pcdc_pkg::CFG_DW-1:0] cfg_wdata = '0;

    int fail_count;
    int waiting_events;
    int burst_left = 0;
    int phase_items = 0;
    int holdoff_requests = 0;
    int holdoffs_done = 0;
    int stall_stretch = 0;
    int idle_cycles = 0;
    ready_style_t stall_style = READY_ALWAYS;
    logic [23:0] cur_limit = pcdc_pkg::CLICK_TIME_LIMIT_RST;
    logic [31:0] cur_dist = pcdc_pkg::DRAG_DISTANCE_SQ_RST;

    pointer_click_drag_classifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    click_drag_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (fail_count),
        .pending   (waiting_events)
    );

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver: random stall styles, plus long hold-offs on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holdoff_requests != holdoffs_done)
            begin
                holdoffs_done++;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            if (stall_stretch == 0)
            begin
                stall_stretch = int'($urandom_range(10, 200));
                stall_style   = ready_style_t'($urandom_range(0, 3));
            end
            stall_stretch--;
            case (stall_style)
                READY_ALWAYS:   m_tready <= 1'b1;
                READY_HALF:     m_tready <= coin();
                READY_SPARSE:   m_tready <= ($urandom_range(0, 4) == 0);
                READY_PERIODIC: m_tready <= (stall_stretch % 3 != 0);
                default:        m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_tick(input logic down, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic hit,
                             input logic [15:0] dt, input logic acc);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(50, 300))
                                                     : int'($urandom_range(1, 20));
            gap = int'($urandom_range(0, 6));
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, acc, dt, hit, y, x, down};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        phase_items++;
    endtask

    task automatic noise_tick();
        send_tick(coin(), 16'($urandom), 16'($urandom), coin(), 16'($urandom), coin());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting_events != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pcdc_pkg::CFG_AW-1:0] idx,
                             input logic [pcdc_pkg::CFG_DW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic gesture(input gesture_t kind);
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        int reach;
        int wobble;
        int small_dt;
        int count;
        reach    = int'($sqrt(real'(cur_dist)));
        wobble   = reach / 3;
        small_dt = (cur_limit / 8 > 65535) ? 65535 : int'(cur_limit / 8);
        if (reach > 8000)
        begin
            px = 16'(-32768 + int'($urandom_range(0, 300)));
            py = 16'(-32768 + int'($urandom_range(0, 300)));
            tx = 16'(32767 - int'($urandom_range(0, 300)));
            ty = 16'(32767 - int'($urandom_range(0, 300)));
        end
        else
        begin
            px = 16'(int'($urandom_range(0, 32000)) - 16000);
            py = 16'(int'($urandom_range(0, 32000)) - 16000);
            tx = 16'(int'(px) + (coin() ? 1 : -1)
                     * (reach + 1 + int'($urandom_range(0, reach / 4 + 1))));
            ty = 16'(int'(py) + jitter(wobble));
        end
        case (kind)
            G_CLICK:
            begin
                send_tick(1'b1, px, py, 1'b1, 16'($urandom), coin());
                repeat ($urandom_range(0, 3))
                    send_tick(1'b1, 16'(int'(px) + jitter(wobble)), py, coin(),
                              16'($urandom_range(0, small_dt)), coin());
                send_tick(1'b0, px, py, coin(), 16'($urandom_range(0, small_dt)),
                          $urandom_range(0, 9) != 0);
                repeat ($urandom_range(1, 3))
                    send_tick(1'b0, 16'($urandom), 16'($urandom), coin(),
                              16'($urandom), coin());
                repeat ($urandom_range(1, 2))
                    send_tick(1'b1, 16'($urandom), 16'($urandom), coin(),
                              16'($urandom), coin());
                send_tick(1'b0, 16'($urandom), 16'($urandom), coin(),
                          16'($urandom), coin());
            end
            G_DRAG:
            begin
                send_tick(1'b1, px, py, 1'b1, 16'($urandom), coin());
                repeat ($urandom_range(0, 2))
                    send_tick(1'b1, 16'(int'(px) + jitter(wobble)), py, coin(),
                              16'($urandom_range(0, small_dt)), coin());
                send_tick(1'b1, tx, ty, coin(), 16'($urandom_range(0, small_dt)),
                          $urandom_range(0, 9) != 0);
                repeat ($urandom_range(1, 10))
                    send_tick(1'b1, 16'($urandom), 16'($urandom), coin(),
                              16'($urandom), coin());
                repeat ($urandom_range(1, 2))
                    send_tick(1'b0, 16'($urandom), 16'($urandom), coin(),
                              16'($urandom), coin());
            end
            G_LONG_PRESS:
            begin
                count = int'(cur_limit / 65535) + 2;
                if (count > 260)
                    count = 260;
                send_tick(1'b1, px, py, 1'b1, 16'($urandom), coin());
                repeat (count)
                    send_tick(1'b1, px, py, coin(), 16'hFFFF, coin());
                send_tick(1'b0, px, py, coin(), 16'($urandom), 1'b1);
            end
            G_REFUSED:
            begin
                send_tick(1'b1, px, py, 1'b1, 16'($urandom), coin());
                send_tick(1'b1, tx, ty, coin(), 16'($urandom_range(0, small_dt)),
                          1'b0);
                send_tick(1'b1, px, py, coin(), 16'($urandom_range(0, small_dt)),
                          coin());
                send_tick(1'b0, px, py, coin(), 16'($urandom_range(0, small_dt)),
                          1'b0);
                repeat ($urandom_range(1, 4))
                    noise_tick();
            end
            G_NOISE:
                repeat ($urandom_range(1, 5))
                    noise_tick();
            default: ;
        endcase
    endtask

    task automatic run_gestures(input gesture_t lead);
        int pick;
        phase_items = 0;
        if (lead != G_NONE)
            gesture(lead);
        while (phase_items < PHASE_ITEMS)
        begin
            pick = int'($urandom_range(0, 11));
            if (pick < 4)
                gesture(G_CLICK);
            else if (pick < 8)
                gesture(G_DRAG);
            else if (pick == 8)
                gesture(G_LONG_PRESS);
            else if (pick == 9)
                gesture(G_REFUSED);
            else
                gesture(G_NOISE);
        end
    endtask

    task automatic run_phase(input logic [31:0] limit_word, input logic [31:0] dist_word,
                             input gesture_t lead, input bit hold);
        drain();
        write_reg(pcdc_pkg::REG_CLICK_TIME_LIMIT, limit_word);
        write_reg(pcdc_pkg::REG_DRAG_DISTANCE_SQ, dist_word);
        write_reg(REG_SPARE_2, $urandom);
        write_reg(REG_SPARE_3, $urandom);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_limit = limit_word[23:0];
        cur_dist  = dist_word;
        if (hold)
            holdoff_requests <= holdoff_requests + 1;
        run_gestures(lead);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick(1'b0, 16'sd0, 16'sd0, 1'b1, 16'd100, 1'b1);
        send_tick(1'b1, 16'sd5, 16'sd5, 1'b0, 16'd100, 1'b1);      // press outside the target
        send_tick(1'b1, 16'sh8000, 16'sh8000, 1'b1, 16'd0, 1'b1);
        send_tick(1'b1, 16'sh8001, 16'sh8000, 1'b1, 16'd10, 1'b1); // move under threshold
        send_tick(1'b1, 16'sd32767, 16'sd32767, 1'b1, 16'hFFFF, 1'b0); // drag start refused
        send_tick(1'b1, 16'sd32767, 16'sd32767, 1'b0, 16'd0, 1'b1);
        send_tick(1'b1, 16'sd100, -16'sd100, 1'b0, 16'd5, 1'b0);
        send_tick(1'b0, 16'sd7, 16'sd8, 1'b0, 16'd5, 1'b1);
        send_tick(1'b1, 16'sd0, 16'sd0, 1'b1, 16'd5, 1'b1);
        send_tick(1'b0, 16'sd0, 16'sd0, 1'b1, 16'd5, 1'b1);
        send_tick(1'b1, 16'sd32767, 16'sh8000, 1'b1, 16'hFFFF, 1'b1);
        send_tick(1'b0, 16'sd32767, 16'sh8000, 1'b1, 16'hFFFF, 1'b0); // click refused
        send_tick(1'b0, 16'sd32767, 16'sh8000, 1'b0, 16'hFFFF, 1'b1);
        send_tick(1'b1, -16'sd1, -16'sd1, 1'b1, 16'd0, 1'b0);
        send_tick(1'b0, -16'sd1, -16'sd1, 1'b1, 16'd0, 1'b0);
        send_tick(1'b1, -16'sd1, -16'sd1, 1'b0, 16'd0, 1'b0);
        send_tick(1'b0, 16'sd2, 16'sd2, 1'b0, 16'd0, 1'b0);
        send_tick(1'b1, 16'sd1, 16'sd1, 1'b1, 16'd0, 1'b1);
        repeat (4) send_tick(1'b1, 16'sd1, 16'sd1, 1'b1, 16'hFFFF, 1'b1);
        send_tick(1'b0, 16'sd1, 16'sd1, 1'b1, 16'd37860, 1'b1);    // release exactly at the limit

        run_gestures(G_NONE);
        run_phase({8'h00, 24'd0}, 32'd0, G_NONE, 1'b0);
        run_phase({8'hFF, 24'hFFFFFF}, 32'hFFFFFFFF, G_LONG_PRESS, 1'b0);
        run_phase({8'h5A, 24'd1000}, 32'd100, G_NONE, 1'b1);
        run_phase({8'h00, 24'd200000}, 32'd1, G_DRAG, 1'b0);
        run_phase($urandom, $urandom_range(0, 10000), G_NONE, 1'b0);
        run_phase($urandom, $urandom, G_NONE, 1'b1);
        run_phase({8'h00, pcdc_pkg::CLICK_TIME_LIMIT_RST}, pcdc_pkg::DRAG_DISTANCE_SQ_RST,
                  G_CLICK, 1'b0);

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && waiting_events == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
